>>> sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Escape-time package
// Widths, fixed-point constants, register indexes and the saturating helper
// that are shared by the interfaces and the escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Basic widths.
  localparam int PIXEL_BITS = 12;
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 16;

  // Derived widths: pitch is one bit narrower, products are double width.
  localparam int STEP_BITS      = COORD_BITS - 1;
  localparam int PROD_BITS      = 2 * COORD_BITS;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  // Range of a coordinate.
  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Escape radius squared (4.0), saturated if the format cannot hold it.
  localparam coord_t FOUR = (FRAC_BITS + 2 >= COORD_BITS - 1) ? CMAX :
                            coord_t'(prod_t'(1) << (FRAC_BITS + 2));

  // Register reset values.
  localparam coord_t                 ORIGIN_RE_RST = coord_t'(-536870912);
  localparam coord_t                 ORIGIN_IM_RST = coord_t'(-402653184);
  localparam logic [STEP_BITS-1:0]   PIXEL_STEP_RST = STEP_BITS'(786432);
  localparam logic [ITER_BITS-1:0]   MAX_ITER_RST   = ITER_BITS'(256);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ORIGIN_RE  = 2'd0,
    REG_ORIGIN_IM  = 2'd1,
    REG_PIXEL_STEP = 2'd2,
    REG_MAX_ITER   = 2'd3
  } cfg_reg_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_coord(input prod_t v);
    logic [PROD_BITS-COORD_BITS:0] hi;
    hi = v[PROD_BITS-1:COORD_BITS-1];
    if (hi == '0 || hi == '1) begin
      return v[COORD_BITS-1:0];
    end else if (v[PROD_BITS-1]) begin
      return CMIN;
    end else begin
      return CMAX;
    end
  endfunction

endpackage

>>> sv/mbe_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one pixel position per item.
// ----------------------------------------------------------------------------
interface mbe_pix_if import mbe_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> sv/mbe_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the iteration count and inside flag.
// ----------------------------------------------------------------------------
interface mbe_res_if import mbe_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ITER_BITS-1:0] iterations;
  logic                 inside_res;

  modport source (output valid, output iterations, output inside_res, input ready);
  modport sink   (input valid, input iterations, input inside_res, output ready);
endinterface

>>> sv/mandelbrot_escape_time.sv
// One item at a time: a new pixel is accepted only in idle, once the previous
// result has entered the result register. Each iteration (at most
// max_iterations) uses the single shared 32x32 multiplier three times,
// and mapping uses it twice.
// Reset (rst, synchronous) returns the sequencer to idle, empties the result
// register and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Maps a pixel to a point c and runs z = z*z + c on one shared multiplier,
// counting iterations until escape or the configured limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  mbe_pix_if.sink                   pix,
  mbe_res_if.source                 res
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MAP_RE  = 9'b000000010,
    ST_MAP_IM  = 9'b000000100,
    ST_MAP_FIN = 9'b000001000,
    ST_IT_A    = 9'b000010000,
    ST_IT_B    = 9'b000100000,
    ST_IT_C    = 9'b001000000,
    ST_IT_D    = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t                 state, state_next;
  coord_t                 origin_re, origin_im;
  logic [STEP_BITS-1:0]   pixel_step;
  logic [ITER_BITS-1:0]   max_iterations;
  logic [PIXEL_BITS-1:0]  px, py;
  coord_t                 c_re, c_im, zx, zy, zx2, zy2;
  logic [ITER_BITS-1:0]   iter_cnt;
  prod_t                  prod;
  coord_t                 mul_a, mul_b;
  coord_t                 map_prod, map_origin, map_res;
  logic signed [COORD_BITS:0]   map_sum;
  logic signed [COORD_BITS+1:0] zx_sum;
  coord_t                 xy_res;
  coord_t                 zx_new, zy_new, sq_res;
  logic signed [COORD_BITS:0]   zy_sum;
  logic [COORD_BITS:0]    esc_sum;
  logic                   keep_going;
  logic                   out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re      <= ORIGIN_RE_RST;
      origin_im      <= ORIGIN_IM_RST;
      pixel_step     <= PIXEL_STEP_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_RE:  origin_re      <= cfg_data;
        REG_ORIGIN_IM:  origin_im      <= cfg_data;
        REG_PIXEL_STEP: pixel_step     <= cfg_data[STEP_BITS-1:0];
        REG_MAX_ITER:   max_iterations <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign pix.ready = (state == ST_IDLE);
  assign out_free  = !res.valid || res.ready;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      ST_MAP_RE: begin
        mul_a = coord_t'(px);
        mul_b = coord_t'(pixel_step);
      end
      ST_MAP_IM: begin
        mul_a = coord_t'(py);
        mul_b = coord_t'(pixel_step);
      end
      ST_IT_B: begin
        mul_a = zx;
        mul_b = zx;
      end
      ST_IT_C: begin
        mul_a = zy;
        mul_b = zy;
      end
      default: begin
        mul_a = zx;
        mul_b = zy;
      end
    endcase
  end

  // Shared multiplier with its product register.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Mapping: origin plus saturated pixel offset, saturated again.
  assign map_prod   = sat_coord(prod);
  assign map_origin = (state == ST_MAP_FIN) ? origin_im : origin_re;
  assign map_sum    = {map_origin[COORD_BITS-1], map_origin}
                    + {map_prod[COORD_BITS-1], map_prod};
  assign map_res    = sat_coord(prod_t'(map_sum));

  // Iteration arithmetic around the product register.
  assign zx_sum  = {{2{zx2[COORD_BITS-1]}}, zx2} - {{2{zy2[COORD_BITS-1]}}, zy2}
                 + {{2{c_re[COORD_BITS-1]}}, c_re};
  assign zx_new  = sat_coord(prod_t'(zx_sum));
  assign xy_res  = sat_coord(prod >>> (FRAC_BITS - 1));
  assign zy_sum  = {xy_res[COORD_BITS-1], xy_res}
                 + {c_im[COORD_BITS-1], c_im};
  assign zy_new  = sat_coord(prod_t'(zy_sum));
  assign sq_res  = sat_coord(prod >>> FRAC_BITS);

  // Escape test; both squares are never negative.
  assign esc_sum    = {1'b0, zx2} + {1'b0, zy2};
  assign keep_going = (iter_cnt < max_iterations) && (esc_sum <= {1'b0, FOUR});

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (pix.valid) state_next = ST_MAP_RE;
      ST_MAP_RE:  state_next = ST_MAP_IM;
      ST_MAP_IM:  state_next = ST_MAP_FIN;
      ST_MAP_FIN: state_next = ST_IT_A;
      ST_IT_A:    state_next = keep_going ? ST_IT_B : ST_DONE;
      ST_IT_B:    state_next = ST_IT_C;
      ST_IT_C:    state_next = ST_IT_D;
      ST_IT_D:    state_next = ST_IT_A;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, loaded by the step the sequencer is in.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pix.valid) begin
          px <= pix.pixel_x;
          py <= pix.pixel_y;
        end
      end
      ST_MAP_IM: c_re <= map_res;
      ST_MAP_FIN: begin
        c_im     <= map_res;
        zx       <= '0;
        zy       <= '0;
        zx2      <= '0;
        zy2      <= '0;
        iter_cnt <= '0;
      end
      ST_IT_A: if (keep_going) zx <= zx_new;
      ST_IT_B: zy <= zy_new;
      ST_IT_C: zx2 <= sq_res;
      ST_IT_D: begin
        zy2      <= sq_res;
        iter_cnt <= iter_cnt + ITER_BITS'(1);
      end
      default: ;
    endcase
  end

  // Result register; it frees the sequencer while the item waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      res.iterations <= iter_cnt;
      res.inside_res <= (iter_cnt == max_iterations);
    end
  end

  // Checks on the sequencer and datapath.
  a_start_map: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> state == ST_MAP_RE)
    else $error("accepted item did not start mapping");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_IT_A |-> iter_cnt <= max_iterations)
    else $error("iteration count passed the limit");

  a_squares_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_IT_A |-> !zx2[COORD_BITS-1] && !zy2[COORD_BITS-1])
    else $error("squared term went negative");

  a_inside_limit: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.inside_res |-> res.iterations == max_iterations)
    else $error("inside flag without reaching the limit");

endmodule

>>> tb/sv/mandelbrot_escape_time_tb.sv
// ----------------------------------------------------------------------------
// Escape-time unit testbench
// Drives pixel items through the escape-time unit under several register
// settings and checks every count and inside flag against an internal
// fixed-point model of the iteration, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb import mbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest silent stretch: an item run to the largest iteration limit.
  localparam int WATCHDOG_LIMIT = 800000;
  localparam int LONG_HOLD      = 400;
  localparam int END_SETTLE     = 50;
  localparam longint ONE        = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic [ITER_BITS-1:0] iterations;
    logic                 inside_res;
  } escape_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]     cfg_data;

  mbe_pix_if pix_ch ();
  mbe_res_if res_ch ();

  mandelbrot_escape_time dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .res       (res_ch)
  );

  // Shadow copy of the configuration registers.
  coord_t                 shadow_origin_re = ORIGIN_RE_RST;
  coord_t                 shadow_origin_im = ORIGIN_IM_RST;
  logic [STEP_BITS-1:0]   shadow_step      = PIXEL_STEP_RST;
  logic [ITER_BITS-1:0]   shadow_limit     = MAX_ITER_RST;

  escape_t pending_escapes[$];

  int errors          = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int burst_left      = 0;
  int quiet_cycles    = 0;
  int holds_asked     = 0;
  int holds_granted   = 0;
  int hold_left       = 0;
  int stall_mode      = 0;
  int stall_left      = 0;

  always #2 clk = ~clk;

  // Clamp a value to the signed coordinate range.
  function automatic longint clamp_coord(input longint v);
    if (v > longint'(CMAX)) begin
      return longint'(CMAX);
    end else if (v < longint'(CMIN)) begin
      return longint'(CMIN);
    end
    return v;
  endfunction

  // Full-width product, floored by a right shift, then clamped.
  function automatic longint fixed_mul(input longint a, input longint b, input int sh);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = a;
    wb = b;
    p = (wa * wb) >>> sh;
    if (p > longint'(CMAX)) begin
      return longint'(CMAX);
    end else if (p < longint'(CMIN)) begin
      return longint'(CMIN);
    end
    return p[63:0];
  endfunction

  // Escape count of one pixel under the current register settings.
  function automatic escape_t predict_escape(input logic [PIXEL_BITS-1:0] px,
                                             input logic [PIXEL_BITS-1:0] py);
    longint c_re;
    longint c_im;
    longint zx;
    longint zy;
    longint zx2;
    longint zy2;
    longint four;
    longint step;
    int unsigned count;
    escape_t r;
    step = shadow_step;
    c_re = clamp_coord(longint'(shadow_origin_re) + fixed_mul(px, step, 0));
    c_im = clamp_coord(longint'(shadow_origin_im) + fixed_mul(py, step, 0));
    four = clamp_coord(longint'(4) << FRAC_BITS);
    zx = 0;
    zy = 0;
    zx2 = 0;
    zy2 = 0;
    count = 0;
    while (count < shadow_limit && zx2 <= four && zy2 <= four - zx2) begin
      zy = clamp_coord(fixed_mul(zx, zy, FRAC_BITS - 1) + c_im);
      zx = clamp_coord(zx2 - zy2 + c_re);
      zx2 = fixed_mul(zx, zx, FRAC_BITS);
      zy2 = fixed_mul(zy, zy, FRAC_BITS);
      count++;
    end
    r.iterations = count[ITER_BITS-1:0];
    r.inside_res = (count == shadow_limit);
    return r;
  endfunction

  // Write all four registers on consecutive edges; the unit must be idle.
  task automatic set_config(input logic [COORD_BITS-1:0] ore,
                            input logic [COORD_BITS-1:0] oim,
                            input logic [COORD_BITS-1:0] step_word,
                            input logic [ITER_BITS-1:0]  limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_RE;
    cfg_data  <= ore;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_IM;
    cfg_data  <= oim;
    @(posedge clk);
    cfg_index <= REG_PIXEL_STEP;
    cfg_data  <= step_word;
    @(posedge clk);
    cfg_index <= REG_MAX_ITER;
    cfg_data  <= {16'($urandom), limit};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_origin_re = ore;
    shadow_origin_im = oim;
    shadow_step      = step_word[STEP_BITS-1:0];
    shadow_limit     = limit;
    settings_used++;
  endtask

  // Offer one pixel item, with a random gap at the start of each burst.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] x, input logic [PIXEL_BITS-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    do @(posedge clk); while (!pix_ch.ready);
    pending_escapes.push_back(predict_escape(x, y));
    burst_left--;
    pixels_sent++;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_for_results();
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_escapes.size() != 0) @(posedge clk);
  endtask

  // Mostly uniform pixel positions, now and then on the edges of the range.
  task automatic send_random_pixel(input int max_x, input int max_y);
    logic [PIXEL_BITS-1:0] x;
    logic [PIXEL_BITS-1:0] y;
    x = PIXEL_BITS'($urandom_range(0, max_x));
    y = PIXEL_BITS'($urandom_range(0, max_y));
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom_range(0, 1) ? '1 : '0;
    end
    if ($urandom_range(0, 9) == 0) begin
      y = $urandom_range(0, 1) ? '1 : '0;
    end
    send_pixel(x, y);
  endtask

  // Register defaults straight after reset.
  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd600, 12'd700);
    wait_for_results();
  endtask

  // A limit of zero runs no iteration and reports the point inside.
  task automatic test_zero_limit();
    set_config(ORIGIN_RE_RST, ORIGIN_IM_RST, 32'(PIXEL_STEP_RST), 16'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd4095, 12'd4095);
    wait_for_results();
  endtask

  // A limit of one.
  task automatic test_single_iteration();
    set_config(ORIGIN_RE_RST, ORIGIN_IM_RST, 32'(PIXEL_STEP_RST), 16'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd4095, 12'd0);
    wait_for_results();
  endtask

  // Origins at the bounds, widest pitch then zero, so mapping and squares saturate.
  task automatic test_saturation();
    set_config(CMAX, CMIN, 32'hFFFF_FFFF, 16'd16);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    wait_for_results();
    set_config(CMIN, CMAX, 32'd0, 16'd16);
    send_pixel(12'd123, 12'd3000);
    wait_for_results();
  endtask

  // Largest limit: the origin stays inside for the full count.
  task automatic test_longest_count();
    set_config(32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd4095);
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while pixels keep coming.
  task automatic test_backpressure();
    set_config(ORIGIN_RE_RST, ORIGIN_IM_RST, 32'(PIXEL_STEP_RST), 16'd3);
    holds_asked++;
    repeat (60) send_random_pixel(4095, 4095);
    wait_for_results();
  endtask

  // Deeper limit over the classic window.
  task automatic test_deep_limit();
    set_config(ORIGIN_RE_RST, ORIGIN_IM_RST, 32'(PIXEL_STEP_RST), MAX_ITER_RST);
    repeat (120) send_random_pixel(1200, 1024);
    wait_for_results();
  endtask

  // Random windows near the set, plus wild settings every few phases.
  task automatic test_random_regions();
    longint ore;
    longint oim;
    logic [COORD_BITS-1:0] step_word;
    logic [ITER_BITS-1:0]  limit;
    int pause_at;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase % 6 == 5) begin
        ore = longint'(signed'($urandom));
        oim = longint'(signed'($urandom));
        step_word = $urandom;
      end else begin
        ore = -(ONE * 9 / 4) + $urandom_range(0, int'(ONE * 3 / 2));
        oim = -(ONE * 3 / 2) + $urandom_range(0, int'(ONE));
        step_word = $urandom_range(1000, 250000);
      end
      limit = (phase % 4 == 3) ? ITER_BITS'($urandom_range(1, 4))
                               : ITER_BITS'($urandom_range(8, 64));
      set_config(32'(ore), 32'(oim), step_word, limit);
      pause_at = $urandom_range(10, 100);
      for (int n = 0; n < 125; n++) begin
        // Let the unit run dry once per phase.
        if (n == pause_at) begin
          wait_for_results();
        end
        send_random_pixel(4095, 4095);
      end
      wait_for_results();
    end
  endtask

  // Receiver ready: its own stall pattern, plus the long hold when asked.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (holds_granted != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_granted++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        case (stall_mode)
          0: begin
            res_ch.ready <= 1'b1;
          end
          1: begin
            res_ch.ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            res_ch.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            res_ch.ready <= (stall_left % 16 < 10);
          end
        endcase
      end
    end
  end

  // Result check against the oldest expectation, and the watchdog.
  always @(posedge clk) begin
    escape_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (pending_escapes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result iterations=%0d inside=%0b", $time,
                   res_ch.iterations, res_ch.inside_res);
        end else begin
          want = pending_escapes.pop_front();
          if (res_ch.iterations !== want.iterations) begin
            errors++;
            $display("%0t: iterations expected %0d actual %0d", $time,
                     want.iterations, res_ch.iterations);
          end
          if (res_ch.inside_res !== want.inside_res) begin
            errors++;
            $display("%0t: inside_res expected %0b actual %0b", $time,
                     want.inside_res, res_ch.inside_res);
          end
        end
      end
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, pending_escapes.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ORIGIN_RE;
    cfg_data       <= '0;
    pix_ch.valid   <= 1'b0;
    pix_ch.pixel_x <= '0;
    pix_ch.pixel_y <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_limit();
    test_single_iteration();
    test_saturation();
    test_longest_count();
    test_backpressure();
    test_deep_limit();
    test_random_regions();

    wait_for_results();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_escapes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_escapes.size());
    end

    $display("Sent %0d pixels under %0d register settings, limits from 0 to 65535.",
             pixels_sent, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
